[hdl/ledf_pkg.sv]
// shared codes and constants for the log entry deframer
`default_nettype none
package ledf_pkg;

    // request codes carried in the input tuser
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_FIND  = 2'd2;

    // event codes carried in the output tuser
    localparam logic [1:0] EV_RECORD  = 2'd0;
    localparam logic [1:0] EV_CORRUPT = 2'd1;
    localparam logic [1:0] EV_END     = 2'd2;

    localparam logic [7:0] HEAD_MAGIC = 8'hCA;
    localparam logic [7:0] FOOT_MAGIC = 8'hBA;

    localparam int STORE_WORDS_DEF = 1024;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 40;

endpackage
`default_nettype wire

[hdl/log_entry_deframer_unit.sv]
// log entry deframer: word store, scan sequencer and result register
// write and start-scan items leave the sequencer idle and give no result
// find-next: accepted in idle, then check and header states per 4-byte step, plus the footer
// state per header candidate; the emit state loads the result register, which waits while a
// result is still held; after the end of the scan a find-next goes straight to emit
// synchronous active-low reset clears the scan state; store contents stay undefined
`default_nettype none
module log_entry_deframer_unit #(
    parameter int STORE_WORDS = ledf_pkg::STORE_WORDS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // word_index[9:0], word_data[41:10], buffer_bytes[54:42], zero fill
    input  wire logic [ledf_pkg::IN_DATA_W-1:0]   s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // payload_offset[12:0], payload_len[20:13] in 8-byte units, record_seq[36:21], zero fill
    output logic [ledf_pkg::OUT_DATA_W-1:0]       m_tdata,
    // event_kind[1:0]
    output logic [1:0]                            m_tuser
);
    import ledf_pkg::*;

    localparam int AW = $clog2(STORE_WORDS);
    localparam int XW = (AW > 11) ? AW : 11;
    localparam logic [18:0] CAP_BYTES = 19'(STORE_WORDS * 4);
    localparam logic [16:0] DEPTH     = 17'(STORE_WORDS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_HEAD,
        S_FOOT,
        S_EMIT
    } t_state;

    t_state      r_state;
    logic [12:0] r_pos;
    logic [12:0] r_limit;
    logic        r_seq_known;
    logic [15:0] r_last_seq;
    logic        r_finished;
    logic [7:0]  r_len;
    logic [15:0] r_seq;
    logic [1:0]  r_res_kind;
    logic [12:0] r_res_off;
    logic [7:0]  r_res_len;
    logic [15:0] r_res_seq;
    logic        r_m_tvalid;
    logic [1:0]  r_m_tuser;
    logic [OUT_DATA_W-1:0] r_m_tdata;

    logic [31:0] r_mem [STORE_WORDS];
    logic [31:0] r_rdata;

    logic        s_acc;
    logic [1:0]  in_op;
    logic [9:0]  in_idx;
    logic [31:0] in_word;
    logic [12:0] in_bytes;
    logic        wr_en;
    logic [XW-1:0] wr_x;
    logic [XW-1:0] rd_x;
    logic [AW-1:0] rd_addr;
    logic [12:0] remain;
    logic [7:0]  h_len;
    logic [15:0] h_seq;
    logic [11:0] h_total;
    logic [12:0] foot_pos;
    logic [11:0] rec_total;
    logic        foot_ok;
    logic        seq_ok;
    logic        out_free;

    assign in_op    = s_tuser;
    assign in_idx   = s_tdata[9:0];
    assign in_word  = s_tdata[41:10];
    assign in_bytes = s_tdata[54:42];

    assign s_tready = (r_state == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign wr_en    = s_acc && (in_op == OP_WRITE) && ({7'd0, in_idx} < DEPTH);
    assign wr_x     = XW'(in_idx);

    // scan position never passes the limit, so this cannot wrap
    assign remain   = r_limit - r_pos;

    assign h_len     = r_rdata[15:8];
    assign h_seq     = r_rdata[31:16];
    assign h_total   = 12'd16 + {1'b0, h_len, 3'b000};
    assign foot_pos  = r_pos + 13'd12 + {2'b00, h_len, 3'b000};
    assign rec_total = 12'd16 + {1'b0, r_len, 3'b000};

    assign foot_ok  = (r_rdata[31:24] == FOOT_MAGIC) && (r_seq != 16'd0)
                   && (r_rdata[15:0] == r_seq) && (r_rdata[23:16] == r_len);
    assign seq_ok   = !r_seq_known || (r_seq == r_last_seq + 16'd1);

    // header word while checking, footer word once the header is seen
    always_comb begin
        if (r_state == S_HEAD) begin
            rd_x = XW'(foot_pos[12:2]);
        end else begin
            rd_x = XW'(r_pos[12:2]);
        end
    end
    assign rd_addr = rd_x[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_x[AW-1:0]] <= in_word;
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign out_free = !r_m_tvalid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_limit     <= '0;
            r_seq_known <= 1'b0;
            r_last_seq  <= '0;
            r_finished  <= 1'b1;
            r_m_tvalid  <= 1'b0;
        end else begin
            // the emit state reloads the output register itself
            if (r_m_tvalid && m_tready && (r_state != S_EMIT)) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        case (in_op)
                            OP_START: begin
                                r_limit     <= ({6'd0, in_bytes} > CAP_BYTES) ?
                                               CAP_BYTES[12:0] : in_bytes;
                                r_pos       <= '0;
                                r_seq_known <= 1'b0;
                                r_last_seq  <= '0;
                                r_finished  <= 1'b0;
                            end
                            OP_FIND: begin
                                if (r_finished) begin
                                    r_res_kind <= EV_END;
                                    r_res_off  <= r_pos;
                                    r_res_len  <= '0;
                                    r_res_seq  <= '0;
                                    r_state    <= S_EMIT;
                                end else begin
                                    r_state <= S_CHECK;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CHECK: begin
                    if (remain >= 13'd8) begin
                        r_state <= S_HEAD;
                    end else begin
                        r_finished <= 1'b1;
                        r_res_kind <= EV_END;
                        r_res_off  <= r_pos;
                        r_res_len  <= '0;
                        r_res_seq  <= '0;
                        r_state    <= S_EMIT;
                    end
                end
                S_HEAD: begin
                    r_len <= h_len;
                    r_seq <= h_seq;
                    if (r_rdata[7:0] != HEAD_MAGIC) begin
                        r_pos   <= r_pos + 13'd4;
                        r_state <= S_CHECK;
                    end else if (remain < {1'b0, h_total}) begin
                        // partial last record
                        r_finished <= 1'b1;
                        r_res_kind <= EV_END;
                        r_res_off  <= r_pos;
                        r_res_len  <= '0;
                        r_res_seq  <= '0;
                        r_state    <= S_EMIT;
                    end else begin
                        r_state <= S_FOOT;
                    end
                end
                S_FOOT: begin
                    r_res_off <= r_pos + 13'd8;
                    r_res_len <= r_len;
                    r_res_seq <= r_seq;
                    if (foot_ok && seq_ok) begin
                        r_res_kind  <= EV_RECORD;
                        r_seq_known <= 1'b1;
                        r_last_seq  <= r_seq;
                        r_pos       <= r_pos + {1'b0, rec_total};
                    end else begin
                        r_res_kind  <= EV_CORRUPT;
                        r_seq_known <= 1'b0;
                        r_pos       <= r_pos + 13'd4;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tuser  <= r_res_kind;
                        r_m_tdata  <= {3'd0, r_res_seq, r_res_len, r_res_off};
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tuser  = r_m_tuser;
    assign m_tdata  = r_m_tdata;

endmodule
`default_nettype wire

[hdl/ledf_checker.sv]
// port-level checks for the log entry deframer, bound to the top level
`default_nettype none
module ledf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        i_s_tready,
    input wire logic [1:0]  i_s_tuser,
    input wire logic        i_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] i_m_tdata,
    input wire logic [1:0]  i_m_tuser
);
    import ledf_pkg::*;

    // a held result keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
            && $stable(i_m_tuser))
        else $error("result changed while stalled");

    // after a write or scan start the input is ready again in the next cycle
    a_short_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready && i_s_tuser != OP_FIND |=> i_s_tready)
        else $error("write or start item held the input");

    // end events carry no length and no sequence
    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser == EV_END |-> i_m_tdata[36:13] == 24'd0)
        else $error("end item with length or sequence");

    // record and candidate payloads sit behind an 8-byte header; event kind 3 never appears
    a_payload_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser != EV_END |-> i_m_tdata[12:3] != 10'd0
            && i_m_tuser != 2'd3)
        else $error("bad event kind or payload offset");

endmodule

bind log_entry_deframer_unit ledf_checker u_ledf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_tvalid),
    .i_s_tready (s_tready),
    .i_s_tuser  (s_tuser),
    .i_m_tvalid (m_tvalid),
    .i_m_tready (m_tready),
    .i_m_tdata  (m_tdata),
    .i_m_tuser  (m_tuser)
);
`default_nettype wire
